// ===== hdl/mkds_pkg.sv =====
// ----------------------------------------------------------------------------
// mkds_pkg
// Shared types and constants of the multi-key draw sorter: cell control,
// controller states, sort modes and port widths.
// ----------------------------------------------------------------------------
package mkds_pkg;

  localparam int HANDLE_W   = 16;
  localparam int DIST_W     = 32;
  localparam int APB_DATA_W = 32;
  localparam int APB_ADDR_W = 3;
  localparam int MODE_W     = 2;

  // register decode on paddr[2]
  localparam logic REG_SORT_MODE = 1'b0;

  localparam logic [MODE_W-1:0] MODE_BY_STATE   = 2'd0;
  localparam logic [MODE_W-1:0] MODE_FAR_FIRST  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_NEAR_FIRST = 2'd2;

  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_LOAD,
    CELL_SORT,
    CELL_SHIFT_OUT
  } cell_op_t;

  typedef enum logic [1:0] {
    ST_LOAD,
    ST_SORT,
    ST_DRAIN
  } state_t;

  typedef struct packed {
    cell_op_t          op;
    logic [MODE_W-1:0] mode;
    logic              parity;
  } cell_ctl_t;

endpackage

// ===== hdl/mkds_cell.sv =====
// ----------------------------------------------------------------------------
// mkds_cell
// One slot of the sorting chain: holds one item, shifts it along the chain
// and does its half of an odd-even compare-exchange with its right neighbour.
// ----------------------------------------------------------------------------
module mkds_cell #(
  parameter int HB  = 16,
  parameter int SB  = 6,
  parameter int IDX = 0,
  localparam int SW = 1 + 5 * HB,
  localparam int DW = SW + mkds_pkg::DIST_W + SB
) (
  input  logic                clk,
  input  mkds_pkg::cell_ctl_t ctl,
  input  logic                pair_en,
  input  logic                swap_left,
  input  logic [DW-1:0]       left_data,
  input  logic [DW-1:0]       right_data,
  output logic [DW-1:0]       data_o,
  output logic                swap_o
);
  import mkds_pkg::*;

  localparam logic IDX_PAR = 1'(IDX % 2);

  logic [DW-1:0] data_r;
  logic [DW-1:0] data_nxt;
  logic [DW-1:0] own_key;
  logic [DW-1:0] right_key;

  // Item layout: {flag, handles, distance, arrival sequence}.
  function automatic logic [DW-1:0] sort_key(input logic [DW-1:0] d,
                                             input logic [MODE_W-1:0] mode);
    logic [SW-1:0]     st;
    logic [DIST_W-1:0] ds;
    logic [SB-1:0]     sq;
    st = d[DW-1 -: SW];
    ds = d[SB +: DIST_W];
    sq = d[SB-1:0];
    case (mode)
      MODE_FAR_FIRST:  sort_key = {~ds, st, sq};
      MODE_NEAR_FIRST: sort_key = {ds, st, sq};
      default:         sort_key = d;
    endcase
  endfunction

  assign own_key   = sort_key(data_r, ctl.mode);
  assign right_key = sort_key(right_data, ctl.mode);

  // the sequence number makes keys distinct, so a strict compare is stable
  assign swap_o = (ctl.op == CELL_SORT) && (ctl.parity == IDX_PAR) && pair_en &&
                  (right_key < own_key);

  always_comb begin
    data_nxt = data_r;
    case (ctl.op)
      CELL_LOAD:      data_nxt = left_data;
      CELL_SHIFT_OUT: data_nxt = right_data;
      CELL_SORT: begin
        if (swap_o) begin
          data_nxt = right_data;
        end else if (swap_left) begin
          data_nxt = left_data;
        end
      end
      default:        data_nxt = data_r;
    endcase
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign data_o = data_r;

endmodule

// ===== hdl/multi_key_draw_sorter_top.sv =====
// ----------------------------------------------------------------------------
// multi_key_draw_sorter_top
// Collects draw items in a chain of cells, sorts them by odd-even
// transposition in the configured key order and streams them out.
// ----------------------------------------------------------------------------
// Loading: one item per cycle, busy stays low until an item marked last.
// After the last item's transfer: n compare-exchange phases across the cell
// chain, one phase per cycle, then n results from the head cell, one per cycle;
// busy stays high throughout, n = items held; the receiver cannot stall.
// Reset clears the controller, counters, overflow flag and mode, not the cells.
module multi_key_draw_sorter_top #(
  parameter int MAX_ITEMS   = 64,
  parameter int HANDLE_BITS = 16
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  output logic                              busy,
  input  logic                              in_uses_meshlets,
  input  logic [mkds_pkg::HANDLE_W-1:0]     in_raster_handle,
  input  logic [mkds_pkg::HANDLE_W-1:0]     in_blend_handle,
  input  logic [mkds_pkg::HANDLE_W-1:0]     in_shader_handle,
  input  logic [mkds_pkg::HANDLE_W-1:0]     in_vertex_handle,
  input  logic [mkds_pkg::HANDLE_W-1:0]     in_index_handle,
  input  logic [mkds_pkg::DIST_W-1:0]       in_distance_key,
  input  logic                              in_last_item,
  output logic                              out_valid,
  output logic                              out_meshlets,
  output logic [mkds_pkg::HANDLE_W-1:0]     out_raster,
  output logic [mkds_pkg::HANDLE_W-1:0]     out_blend,
  output logic [mkds_pkg::HANDLE_W-1:0]     out_shader,
  output logic [mkds_pkg::HANDLE_W-1:0]     out_vertex,
  output logic [mkds_pkg::HANDLE_W-1:0]     out_index,
  output logic [mkds_pkg::DIST_W-1:0]       out_distance,
  output logic                              out_end_of_run,
  output logic                              out_items_dropped,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [mkds_pkg::APB_ADDR_W-1:0]   paddr,
  input  logic [mkds_pkg::APB_DATA_W-1:0]   pwdata,
  output logic [mkds_pkg::APB_DATA_W-1:0]   prdata,
  output logic                              pready
);
  import mkds_pkg::*;

  localparam int HB    = HANDLE_BITS;
  localparam int SB    = $clog2(MAX_ITEMS);
  localparam int CNT_W = $clog2(MAX_ITEMS + 1);
  localparam int SW    = 1 + 5 * HB;
  localparam int DW    = SW + DIST_W + SB;

  state_t            state_r, state_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic [CNT_W-1:0]  phase_r, phase_nxt;
  logic              ovf_r, ovf_nxt;
  logic [MODE_W-1:0] mode_r, mode_nxt;
  logic [MODE_W-1:0] sort_mode_r, sort_mode_nxt;

  logic              out_valid_r, out_valid_nxt;
  logic              out_end_r, out_end_nxt;
  logic              out_drop_r, out_drop_nxt;
  logic [DW-1:0]     out_data_r, out_data_nxt;

  cell_ctl_t         ctl;
  logic              in_xfer;
  logic              cfg_wr;
  logic [DW-1:0]     new_item;
  logic [DW-1:0]     cell_data [MAX_ITEMS];
  logic              swap      [MAX_ITEMS];

  assign in_xfer = start && !busy;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign pready  = 1'b1;
  assign prdata  = (paddr[2] == REG_SORT_MODE) ? APB_DATA_W'(mode_r) : '0;
  assign mode_nxt = (cfg_wr && paddr[2] == REG_SORT_MODE) ? pwdata[MODE_W-1:0] : mode_r;

  assign new_item = {in_uses_meshlets,
                     HB'(in_raster_handle), HB'(in_blend_handle),
                     HB'(in_shader_handle), HB'(in_vertex_handle),
                     HB'(in_index_handle), in_distance_key, count_r[SB-1:0]};

  // ---------------------------------------------------------------- cell chain
  for (genvar i = 0; i < MAX_ITEMS; i++) begin : g_cell
    logic [DW-1:0] left_d;
    logic [DW-1:0] right_d;
    logic          swap_l;
    logic          pair_en;

    if (i == 0) begin : g_head
      assign left_d = new_item;
      assign swap_l = 1'b0;
    end else begin : g_body
      assign left_d = cell_data[i-1];
      assign swap_l = swap[i-1];
    end

    if (i == MAX_ITEMS - 1) begin : g_tail
      assign right_d = '0;
    end else begin : g_next
      assign right_d = cell_data[i+1];
    end

    assign pair_en = (CNT_W'(i + 1) < count_r);

    mkds_cell #(
      .HB  (HB),
      .SB  (SB),
      .IDX (i)
    ) u_cell (
      .clk        (clk),
      .ctl        (ctl),
      .pair_en    (pair_en),
      .swap_left  (swap_l),
      .left_data  (left_d),
      .right_data (right_d),
      .data_o     (cell_data[i]),
      .swap_o     (swap[i])
    );
  end

  // ---------------------------------------------------------------- control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_LOAD;
      count_r     <= '0;
      phase_r     <= '0;
      ovf_r       <= 1'b0;
      mode_r      <= MODE_BY_STATE;
      sort_mode_r <= MODE_BY_STATE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      phase_r     <= phase_nxt;
      ovf_r       <= ovf_nxt;
      mode_r      <= mode_nxt;
      sort_mode_r <= sort_mode_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_end_r  <= out_end_nxt;
    out_drop_r <= out_drop_nxt;
    out_data_r <= out_data_nxt;
  end

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    phase_nxt     = phase_r;
    ovf_nxt       = ovf_r;
    sort_mode_nxt = sort_mode_r;
    out_valid_nxt = 1'b0;
    out_end_nxt   = out_end_r;
    out_drop_nxt  = out_drop_r;
    out_data_nxt  = out_data_r;
    ctl.op        = CELL_HOLD;
    ctl.mode      = sort_mode_r;
    ctl.parity    = phase_r[0];
    busy          = 1'b1;

    case (state_r)
      ST_LOAD: begin
        busy = 1'b0;
        if (start) begin
          if (count_r != CNT_W'(MAX_ITEMS)) begin
            ctl.op    = CELL_LOAD;
            count_nxt = count_r + CNT_W'(1);
          end else begin
            // store full: drop the item, flag the set
            ovf_nxt = 1'b1;
          end
          if (in_last_item) begin
            sort_mode_nxt = mode_r;
            phase_nxt     = '0;
            state_nxt     = ST_SORT;
          end
        end
      end
      ST_SORT: begin
        ctl.op    = CELL_SORT;
        phase_nxt = phase_r + CNT_W'(1);
        if (phase_r == count_r - CNT_W'(1)) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        ctl.op        = CELL_SHIFT_OUT;
        out_valid_nxt = 1'b1;
        out_data_nxt  = cell_data[0];
        out_drop_nxt  = ovf_r;
        out_end_nxt   = (count_r == CNT_W'(1));
        count_nxt     = count_r - CNT_W'(1);
        if (count_r == CNT_W'(1)) begin
          ovf_nxt   = 1'b0;
          state_nxt = ST_LOAD;
        end
      end
      default: begin
        state_nxt = ST_LOAD;
      end
    endcase
  end

  // ---------------------------------------------------------------- results
  assign out_valid         = out_valid_r;
  assign out_end_of_run    = out_end_r;
  assign out_items_dropped = out_drop_r;
  assign out_meshlets      = out_data_r[DW-1];
  assign out_raster        = HANDLE_W'(out_data_r[DW-2 -: HB]);
  assign out_blend         = HANDLE_W'(out_data_r[DW-2-HB -: HB]);
  assign out_shader        = HANDLE_W'(out_data_r[DW-2-2*HB -: HB]);
  assign out_vertex        = HANDLE_W'(out_data_r[DW-2-3*HB -: HB]);
  assign out_index         = HANDLE_W'(out_data_r[DW-2-4*HB -: HB]);
  assign out_distance      = out_data_r[SB +: DIST_W];

  // ---------------------------------------------------------------- checks
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(MAX_ITEMS))
    else $error("held count beyond capacity");

  a_last_goes_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer && in_last_item |=> busy)
    else $error("last item did not start sorting");

  a_result_from_drain: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(state_r == ST_DRAIN))
    else $error("result outside drain");

  a_end_closes_run: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_end_of_run |-> state_r == ST_LOAD && count_r == '0)
    else $error("end of run while items remain");

  a_sort_phase: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_SORT |-> phase_r < count_r)
    else $error("sort phase overrun");

endmodule

// ===== bench/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for multi_key_draw_sorter_top. Sends draw sets through
// the start/busy port and programs the sort mode over APB. A local model
// stable-sorts each finished set, and every output strobe is compared
// against the oldest predicted record.
// ----------------------------------------------------------------------------
module testbench;
  import mkds_pkg::*;

  localparam int          MAX_ITEMS    = 64;
  localparam int          LIMIT_CYCLES = 250000;
  localparam int          DRAIN_SLACK  = 4;
  localparam int          REPORT_CAP   = 50;
  localparam logic [1:0]  MODE_UNUSED  = 2'd3;
  localparam logic [APB_ADDR_W-1:0] MODE_ADDR = {REG_SORT_MODE, 2'b00};

  typedef struct packed {
    logic                meshlets;
    logic [HANDLE_W-1:0] raster;
    logic [HANDLE_W-1:0] blend;
    logic [HANDLE_W-1:0] shader;
    logic [HANDLE_W-1:0] vertex;
    logic [HANDLE_W-1:0] index;
    logic [DIST_W-1:0]   distance;
  } draw_t;

  typedef struct packed {
    draw_t draw;
    logic  end_of_run;
    logic  dropped;
  } sorted_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic                in_uses_meshlets = 1'b0;
  logic [HANDLE_W-1:0] in_raster_handle = '0;
  logic [HANDLE_W-1:0] in_blend_handle  = '0;
  logic [HANDLE_W-1:0] in_shader_handle = '0;
  logic [HANDLE_W-1:0] in_vertex_handle = '0;
  logic [HANDLE_W-1:0] in_index_handle  = '0;
  logic [DIST_W-1:0]   in_distance_key  = '0;
  logic                in_last_item     = 1'b0;
  logic                out_valid;
  logic                out_meshlets;
  logic [HANDLE_W-1:0] out_raster;
  logic [HANDLE_W-1:0] out_blend;
  logic [HANDLE_W-1:0] out_shader;
  logic [HANDLE_W-1:0] out_vertex;
  logic [HANDLE_W-1:0] out_index;
  logic [DIST_W-1:0]   out_distance;
  logic                out_end_of_run;
  logic                out_items_dropped;
  logic                  psel    = 1'b0;
  logic                  penable = 1'b0;
  logic                  pwrite  = 1'b0;
  logic [APB_ADDR_W-1:0] paddr   = '0;
  logic [APB_DATA_W-1:0] pwdata  = '0;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;

  // sorter model
  draw_t      held_draws[$];
  logic       held_overflow = 1'b0;
  logic [1:0] active_mode = MODE_BY_STATE;
  sorted_t    pending_sorted[$];

  int  errors = 0;
  int  cycles = 0;
  bit  steady = 1'b0;

  multi_key_draw_sorter_top #(
    .MAX_ITEMS   (MAX_ITEMS),
    .HANDLE_BITS (HANDLE_W)
  ) dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .start             (start),
    .busy              (busy),
    .in_uses_meshlets  (in_uses_meshlets),
    .in_raster_handle  (in_raster_handle),
    .in_blend_handle   (in_blend_handle),
    .in_shader_handle  (in_shader_handle),
    .in_vertex_handle  (in_vertex_handle),
    .in_index_handle   (in_index_handle),
    .in_distance_key   (in_distance_key),
    .in_last_item      (in_last_item),
    .out_valid         (out_valid),
    .out_meshlets      (out_meshlets),
    .out_raster        (out_raster),
    .out_blend         (out_blend),
    .out_shader        (out_shader),
    .out_vertex        (out_vertex),
    .out_index         (out_index),
    .out_distance      (out_distance),
    .out_end_of_run    (out_end_of_run),
    .out_items_dropped (out_items_dropped),
    .psel              (psel),
    .penable           (penable),
    .pwrite            (pwrite),
    .paddr             (paddr),
    .pwdata            (pwdata),
    .prdata            (prdata),
    .pready            (pready)
  );

  always #6 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT_CYCLES) begin
      $display("multi_key_draw_sorter_top verification failed");
      $finish;
    end
  end

  // Lexicographic precedence: 1 when a must leave strictly before b.
  function automatic bit leaves_first(draw_t a, draw_t b, logic [1:0] mode);
    logic [1+5*HANDLE_W-1:0] sa, sb;
    sa = {a.meshlets, a.raster, a.blend, a.shader, a.vertex, a.index};
    sb = {b.meshlets, b.raster, b.blend, b.shader, b.vertex, b.index};
    case (mode)
      MODE_FAR_FIRST:
        return (a.distance > b.distance) || (a.distance == b.distance && sa < sb);
      MODE_NEAR_FIRST:
        return (a.distance < b.distance) || (a.distance == b.distance && sa < sb);
      default:
        return {sa, a.distance} < {sb, b.distance};
    endcase
  endfunction

  // Store the draw; on the closing draw, stable-sort the set into the queue.
  function automatic void accept_draw(draw_t d, bit last);
    draw_t ordered[$];
    int    j;
    if (held_draws.size() < MAX_ITEMS)
      held_draws.push_back(d);
    else
      held_overflow = 1'b1;
    if (!last)
      return;
    foreach (held_draws[i]) begin
      j = ordered.size();
      while (j > 0 && leaves_first(held_draws[i], ordered[j-1], active_mode))
        j--;
      ordered.insert(j, held_draws[i]);
    end
    foreach (ordered[i])
      pending_sorted.push_back('{draw: ordered[i], end_of_run: (i == ordered.size() - 1),
                                 dropped: held_overflow});
    held_draws.delete();
    held_overflow = 1'b0;
  endfunction

  always @(posedge clk) begin : check_result
    sorted_t seen, want;
    if (rst_n && out_valid) begin
      seen = '{draw: '{out_meshlets, out_raster, out_blend, out_shader, out_vertex,
                       out_index, out_distance},
               end_of_run: out_end_of_run, dropped: out_items_dropped};
      if (pending_sorted.size() == 0) begin
        errors++;
        if (errors <= REPORT_CAP)
          $display("%0t: unexpected result, expected none, got %h", $time, seen);
      end else begin
        want = pending_sorted.pop_front();
        if (seen !== want) begin
          errors++;
          if (errors <= REPORT_CAP)
            $display({"%0t: mismatch expected mesh %0d ras %h bl %h sh %h vx %h ix %h ",
                      "dist %h end %0d drop %0d / got mesh %0d ras %h bl %h sh %h vx %h ",
                      "ix %h dist %h end %0d drop %0d"}, $time,
                     want.draw.meshlets, want.draw.raster, want.draw.blend,
                     want.draw.shader, want.draw.vertex, want.draw.index,
                     want.draw.distance, want.end_of_run, want.dropped,
                     seen.draw.meshlets, seen.draw.raster, seen.draw.blend,
                     seen.draw.shader, seen.draw.vertex, seen.draw.index,
                     seen.draw.distance, seen.end_of_run, seen.dropped);
        end
      end
    end
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (steady || r < 50)
      return 0;
    if (r < 90)
      return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [HANDLE_W-1:0] rand_handle();
    case ($urandom_range(0, 3))
      0:       return HANDLE_W'($urandom_range(0, 3));
      1:       return HANDLE_W'({HANDLE_W{1'b1}} - $urandom_range(0, 1));
      default: return HANDLE_W'($urandom());
    endcase
  endfunction

  // Bias towards a few shared distances so ties reach the state keys.
  function automatic logic [DIST_W-1:0] rand_distance();
    if ($urandom_range(0, 2) != 0)
      return $urandom();
    case ($urandom_range(0, 3))
      0:       return 32'h0000_0000;
      1:       return 32'h3F80_0000;
      2:       return 32'h7F80_0000;
      default: return 32'hFFFF_FFFF;
    endcase
  endfunction

  function automatic draw_t rand_draw();
    draw_t d;
    d.meshlets = 1'($urandom_range(0, 1));
    d.raster   = rand_handle();
    d.blend    = rand_handle();
    d.shader   = rand_handle();
    d.vertex   = rand_handle();
    d.index    = rand_handle();
    d.distance = rand_distance();
    return d;
  endfunction

  // Hold start until the transfer; start stays high when no gap follows.
  task automatic send_draw(draw_t d, bit last);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start            <= 1'b1;
    in_uses_meshlets <= d.meshlets;
    in_raster_handle <= d.raster;
    in_blend_handle  <= d.blend;
    in_shader_handle <= d.shader;
    in_vertex_handle <= d.vertex;
    in_index_handle  <= d.index;
    in_distance_key  <= d.distance;
    in_last_item     <= last;
    do @(posedge clk); while (busy);
    accept_draw(d, last);
  endtask

  task automatic send_random_set(int count);
    for (int k = 0; k < count; k++)
      send_draw(rand_draw(), k == count - 1);
  endtask

  task automatic wait_drained();
    start <= 1'b0;
    while (pending_sorted.size() != 0) @(posedge clk);
    while (busy) @(posedge clk);
    repeat (DRAIN_SLACK) @(posedge clk);
  endtask

  // Write the mode register, then read it back.
  task automatic program_mode(logic [1:0] mode);
    wait_drained();
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    penable <= 1'b0;
    paddr   <= MODE_ADDR;
    pwdata  <= APB_DATA_W'(mode);
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    active_mode = mode;
    pwrite  <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata[MODE_W-1:0] !== mode) begin
      errors++;
      $display("%0t: mode readback expected %0d got %0d", $time, mode,
               prdata[MODE_W-1:0]);
    end
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic test_extremes();
    draw_t lo, hi, d;
    lo = '0;
    hi = '1;
    program_mode(MODE_BY_STATE);
    send_draw(hi, 1'b0);
    send_draw(lo, 1'b0);
    d = hi;
    d.distance = 32'h8000_0000;
    send_draw(d, 1'b0);
    d = lo;
    d.distance = 32'h7F80_0000;
    send_draw(d, 1'b0);
    d = lo;
    d.meshlets = 1'b1;
    d.distance = 32'hFFFF_FFFF;
    send_draw(d, 1'b1);
    // single-draw sets
    send_draw(lo, 1'b1);
    send_draw(hi, 1'b1);
  endtask

  // Near-identical draws, differing in up to two keys, under modes 1, 2 and 3.
  task automatic test_key_order();
    draw_t       base;
    draw_t       v[6];
    logic [1:0]  modes[3];
    int          arrival[6];
    base = '{1'b0, 16'h1000, 16'h2000, 16'h3000, 16'h4000, 16'h5000, 32'h3F80_0000};
    foreach (v[i]) v[i] = base;
    v[1].index    = 16'h5001;
    v[2].meshlets = 1'b1;
    v[3].distance = 32'h4000_0000;
    v[3].raster   = 16'h0000;
    v[4].distance = 32'h3F00_0000;
    v[4].blend    = 16'hFFFF;
    arrival = '{2, 1, 4, 0, 3, 5};
    modes   = '{MODE_FAR_FIRST, MODE_NEAR_FIRST, MODE_UNUSED};
    foreach (modes[m]) begin
      program_mode(modes[m]);
      foreach (arrival[k])
        send_draw(v[arrival[k]], k == 5);
    end
  endtask

  task automatic test_random_sets(int budget);
    int sent;
    int size;
    sent = 0;
    while (sent < budget) begin
      if ($urandom_range(0, 2) == 0)
        program_mode(2'($urandom_range(0, 3)));
      size = ($urandom_range(0, 9) == 0) ? $urandom_range(16, 40) : $urandom_range(1, 8);
      steady = ($urandom_range(0, 3) == 0);
      send_random_set(size);
      steady = 1'b0;
      sent += size;
      // now and then, hold off until the whole set has been streamed out
      if ($urandom_range(0, 3) == 0)
        wait_drained();
    end
  endtask

  task automatic test_overflow();
    program_mode(MODE_NEAR_FIRST);
    send_random_set(MAX_ITEMS);
    program_mode(MODE_FAR_FIRST);
    send_random_set(MAX_ITEMS + 6);
    // closing draw finds the store full: dropped but still ends the set
    program_mode(MODE_BY_STATE);
    send_random_set(MAX_ITEMS + 1);
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_extremes();
    test_key_order();
    test_random_sets(190);
    test_overflow();
    wait_drained();
    if (errors == 0)
      $display("multi_key_draw_sorter_top verification clean");
    else
      $display("multi_key_draw_sorter_top verification failed");
    $finish;
  end

endmodule

// ===== multi_key_draw_sorter_top.f =====
hdl/mkds_pkg.sv
hdl/mkds_cell.sv
hdl/multi_key_draw_sorter_top.sv
bench/testbench.sv
